>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the allocator RTL. They compile to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property checked at every clock edge outside reset.
`define FPBA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fpba assertion failed");
// Trigger in one cycle, consequence in the next.
`define FPBA_ASSERT_NEXT(lbl, clk, rst, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("fpba assertion failed");
`else
`define FPBA_ASSERT(lbl, clk, rst, prop)
`define FPBA_ASSERT_NEXT(lbl, clk, rst, trig, cons)
`endif

`endif

>>> hdl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Types, constants and codes of the fit-policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  // Table geometry
  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_WIDTH = 16;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

  // Fixed field widths on the channels
  localparam int BLOCK_INDEX_W = 4;
  localparam int SIZE_FIELD_W  = 16;
  localparam int POLICY_W      = 2;
  localparam int BLOCKS_CFG_W  = 5;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic {
    REG_FIT_POLICY    = 1'b0,
    REG_BLOCKS_IN_USE = 1'b1
  } reg_idx_t;

  typedef enum logic [POLICY_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_t;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [POLICY_W-1:0]     fit_policy;
    logic [BLOCKS_CFG_W-1:0] blocks_in_use;
  } cfg_t;

  typedef struct packed {
    logic                  filled;
    logic [SIZE_WIDTH-1:0] size;
  } entry_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_W-1:0]      addr;
    entry_t                data;
  } tbl_wr_t;

  typedef struct packed {
    logic [POLICY_W-1:0]   policy;
    logic [SIZE_WIDTH-1:0] req_size;
    entry_t                cand;
    logic                  found;
    logic [SIZE_WIDTH-1:0] best_size;
  } fit_req_t;

  typedef struct packed {
    logic                  take;
    logic [SIZE_WIDTH-1:0] left_over;
  } fit_rsp_t;

endpackage

`default_nettype wire

>>> hdl/fpba_in_if.sv
// ----------------------------------------------------------------------------
// fpba_in_if
// Request channel: load or allocate words with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic [fpba_pkg::BLOCK_INDEX_W-1:0]     block_index;
  logic [fpba_pkg::SIZE_FIELD_W-1:0]      block_size;
  logic                                   initially_filled;
  logic [fpba_pkg::SIZE_FIELD_W-1:0]      request_size;

  modport source (
    output valid, req_type, block_index, block_size, initially_filled, request_size,
    input  ready
  );
  modport sink (
    input  valid, req_type, block_index, block_size, initially_filled, request_size,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/fpba_out_if.sv
// ----------------------------------------------------------------------------
// fpba_out_if
// Result channel: one word per allocate, with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpba_out_if;
  logic                                valid;
  logic                                ready;
  logic                                granted;
  logic [fpba_pkg::BLOCK_INDEX_W-1:0]  chosen_block;
  logic [fpba_pkg::SIZE_FIELD_W-1:0]   left_over;

  modport source (
    output valid, granted, chosen_block, left_over,
    input  ready
  );
  modport sink (
    input  valid, granted, chosen_block, left_over,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/fpba_cfg_regs.sv
// ----------------------------------------------------------------------------
// fpba_cfg_regs
// APB register file: fit policy and number of blocks in use.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpba_pkg::ADDR_W-1:0]   paddr,
  input  logic [fpba_pkg::DATA_W-1:0]   pwdata,
  output logic [fpba_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output fpba_pkg::cfg_t                cfg
);

  fpba_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  // Address decode, one register per word
  assign reg_idx = fpba_pkg::reg_idx_t'(paddr[fpba_pkg::ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        fpba_pkg::REG_FIT_POLICY:    cfg.fit_policy    <= pwdata[fpba_pkg::POLICY_W-1:0];
        fpba_pkg::REG_BLOCKS_IN_USE: cfg.blocks_in_use <= pwdata[fpba_pkg::BLOCKS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      fpba_pkg::REG_FIT_POLICY:    prdata = fpba_pkg::DATA_W'(cfg.fit_policy);
      fpba_pkg::REG_BLOCKS_IN_USE: prdata = fpba_pkg::DATA_W'(cfg.blocks_in_use);
      default:                     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/fpba_table.sv
// ----------------------------------------------------------------------------
// fpba_table
// Block table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_table (
  input  logic                        clk,
  input  fpba_pkg::tbl_wr_t           wr,
  input  logic [fpba_pkg::IDX_W-1:0]  rd_addr,
  output fpba_pkg::entry_t            rd_data
);

  fpba_pkg::entry_t mem [fpba_pkg::NUM_BLOCKS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/fpba_fit_unit.sv
// ----------------------------------------------------------------------------
// fpba_fit_unit
// Shared compare unit: decides whether the current entry replaces the best
// candidate, and forms the leftover size of the best candidate.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_fit_unit (
  input  fpba_pkg::fit_req_t  fit_req,
  output fpba_pkg::fit_rsp_t  fit_rsp
);

  logic fits;
  logic better;

  // Free and large enough
  assign fits = !fit_req.cand.filled && (fit_req.cand.size >= fit_req.req_size);

  // Policy compare; ties keep the lower index
  always_comb begin
    case (fit_req.policy)
      fpba_pkg::FIT_BEST:  better = fit_req.cand.size < fit_req.best_size;
      fpba_pkg::FIT_WORST: better = fit_req.cand.size > fit_req.best_size;
      default:             better = 1'b0;
    endcase
  end

  assign fit_rsp.take      = fits && (!fit_req.found || better);
  assign fit_rsp.left_over = fit_req.best_size - fit_req.req_size;

endmodule

`default_nettype wire

>>> hdl/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: takes request words, writes loads, scans the table one entry
// per cycle through the fit unit, updates the chosen entry and holds the
// result word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fpba_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  fpba_pkg::cfg_t              cfg,
  fpba_in_if.sink                     req,
  fpba_out_if.source                  rsp,
  output fpba_pkg::tbl_wr_t           tbl_wr,
  output logic [fpba_pkg::IDX_W-1:0]  rd_addr,
  input  fpba_pkg::entry_t            rd_data,
  output fpba_pkg::fit_req_t          fit_req,
  input  fpba_pkg::fit_rsp_t          fit_rsp
);

  fpba_pkg::state_t                   state;
  fpba_pkg::state_t                   state_next;
  logic [fpba_pkg::SIZE_WIDTH-1:0]    req_size;
  logic [fpba_pkg::CNT_W-1:0]         cnt;
  logic [fpba_pkg::CNT_W-1:0]         cnt_cfg;
  logic [fpba_pkg::CNT_W-1:0]         issue_idx;
  logic                               pend_valid;
  logic [fpba_pkg::IDX_W-1:0]         pend_idx;
  logic                               found;
  logic [fpba_pkg::IDX_W-1:0]         best_idx;
  logic [fpba_pkg::SIZE_WIDTH-1:0]    best_size;
  logic                               out_valid;
  logic                               out_granted;
  logic [fpba_pkg::BLOCK_INDEX_W-1:0] out_block;
  logic [fpba_pkg::SIZE_FIELD_W-1:0]  out_left;

  logic accept;
  logic is_alloc;
  logic load_ok;
  logic issue_more;
  logic scan_end;
  logic out_free;

  // Handshake and scan status
  assign accept     = req.valid && req.ready;
  assign is_alloc   = req.req_type == fpba_pkg::REQ_ALLOC;
  assign load_ok    = 32'(req.block_index) < fpba_pkg::NUM_BLOCKS;
  assign cnt_cfg    = (32'(cfg.blocks_in_use) > fpba_pkg::NUM_BLOCKS) ?
                      fpba_pkg::CNT_W'(fpba_pkg::NUM_BLOCKS) :
                      fpba_pkg::CNT_W'(cfg.blocks_in_use);
  assign issue_more = issue_idx < cnt;
  assign scan_end   = !issue_more && !pend_valid;
  assign out_free   = !out_valid || rsp.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fpba_pkg::ST_IDLE: begin
        if (accept && is_alloc) state_next = fpba_pkg::ST_SCAN;
      end
      fpba_pkg::ST_SCAN: begin
        if (scan_end) state_next = fpba_pkg::ST_UPDATE;
      end
      fpba_pkg::ST_UPDATE: begin
        if (out_free) state_next = fpba_pkg::ST_IDLE;
      end
      default: state_next = fpba_pkg::ST_IDLE;
    endcase
  end

  // Outputs: request ready, table write, read address, fit unit operands
  always_comb begin
    req.ready = 1'b0;
    tbl_wr    = '0;
    case (state)
      fpba_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (accept && !is_alloc && load_ok) begin
          tbl_wr.en          = 1'b1;
          tbl_wr.addr        = fpba_pkg::IDX_W'(req.block_index);
          tbl_wr.data.size   = fpba_pkg::SIZE_WIDTH'(req.block_size);
          tbl_wr.data.filled = req.initially_filled;
        end
      end
      fpba_pkg::ST_UPDATE: begin
        if (out_free && found) begin
          tbl_wr.en          = 1'b1;
          tbl_wr.addr        = best_idx;
          tbl_wr.data.size   = fit_rsp.left_over;
          tbl_wr.data.filled = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rd_addr           = issue_idx[fpba_pkg::IDX_W-1:0];
  assign fit_req.policy    = cfg.fit_policy;
  assign fit_req.req_size  = req_size;
  assign fit_req.cand      = rd_data;
  assign fit_req.found     = found;
  assign fit_req.best_size = best_size;

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fpba_pkg::ST_IDLE;
      issue_idx  <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // Start of an allocate
      if (state == fpba_pkg::ST_IDLE && accept && is_alloc) begin
        req_size   <= fpba_pkg::SIZE_WIDTH'(req.request_size);
        cnt        <= cnt_cfg;
        issue_idx  <= '0;
        pend_valid <= 1'b0;
        found      <= 1'b0;
      end

      // Scan: issue one read, judge the entry read last cycle
      if (state == fpba_pkg::ST_SCAN) begin
        pend_valid <= issue_more;
        pend_idx   <= issue_idx[fpba_pkg::IDX_W-1:0];
        if (issue_more) issue_idx <= issue_idx + 1'b1;
        if (pend_valid && fit_rsp.take) begin
          found     <= 1'b1;
          best_idx  <= pend_idx;
          best_size <= rd_data.size;
        end
      end

      // Result word into the output register
      if (state == fpba_pkg::ST_UPDATE && out_free) begin
        out_valid   <= 1'b1;
        out_granted <= found;
        out_block   <= found ? fpba_pkg::BLOCK_INDEX_W'(best_idx) : '0;
        out_left    <= found ? fpba_pkg::SIZE_FIELD_W'(fit_rsp.left_over) : '0;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.granted      = out_granted;
  assign rsp.chosen_block = out_block;
  assign rsp.left_over    = out_left;

  // Checks
  `FPBA_ASSERT(a_best_in_range, clk, rst, found |-> (32'(best_idx) < 32'(cnt)))
  `FPBA_ASSERT(a_pend_in_range, clk, rst, pend_valid |-> (32'(pend_idx) < 32'(cnt)))
  `FPBA_ASSERT_NEXT(a_alloc_busy, clk, rst, accept && is_alloc, state == fpba_pkg::ST_SCAN)
  `FPBA_ASSERT(a_wr_window, clk, rst, tbl_wr.en |-> (state == fpba_pkg::ST_IDLE || state == fpba_pkg::ST_UPDATE))

endmodule

`default_nettype wire

>>> hdl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Block allocator with first, best and worst fit over a 16-entry table.
//
// Channels: req carries load and allocate words, rsp returns one result word
// per allocate, both valid/ready. The APB port sets fit_policy (0x0) and
// blocks_in_use (0x4); write them only while the block is idle.
// A load word is written to the table as it is accepted and yields no result; the next word can
// follow in the next cycle.
// An allocate scans the first blocks_in_use entries (at most 16), one entry
// per cycle through a single compare unit and a registered table read port.
// Its result passes through the SCAN and UPDATE states into the output
// register, and req is not ready while the allocate is in those states.
// The result sits in an output register: while rsp is stalled, loads are
// still taken, and a following allocate waits after its scan until the
// register is free.
// Reset clears the configuration registers and control state; table entries are
// undefined until loaded, so load each entry before any allocate scans it.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator (
  input  logic                         clk,
  input  logic                         rst,
  fpba_in_if.sink                      req,
  fpba_out_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpba_pkg::ADDR_W-1:0]  paddr,
  input  logic [fpba_pkg::DATA_W-1:0]  pwdata,
  output logic [fpba_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  fpba_pkg::cfg_t               cfg;
  fpba_pkg::tbl_wr_t            tbl_wr;
  logic [fpba_pkg::IDX_W-1:0]   rd_addr;
  fpba_pkg::entry_t             rd_data;
  fpba_pkg::fit_req_t           fit_req;
  fpba_pkg::fit_rsp_t           fit_rsp;

  // Configuration registers
  fpba_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Block table
  fpba_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared compare unit
  fpba_fit_unit u_fit (
    .fit_req (fit_req),
    .fit_rsp (fit_rsp)
  );

  // Sequencer and output register
  fpba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .req     (req),
    .rsp     (rsp),
    .tbl_wr  (tbl_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .fit_req (fit_req),
    .fit_rsp (fit_rsp)
  );

endmodule

`default_nettype wire

>>> verif/fit_policy_block_allocator_test.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_test
// Self-checking bench for the fit-policy block allocator. Load and allocate
// words go in over the request channel. Grant words come back over the
// result channel. A shadow copy of the block table predicts every grant
// under first, best and worst fit. Directed cases come first, then random
// traffic under several idle patterns, then a long result-side hold-off.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_test;

  // Policy code with no name in the package; behaves as first fit
  localparam logic [fpba_pkg::POLICY_W-1:0] FIT_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    fpba_pkg::req_type_t                kind;
    logic [fpba_pkg::BLOCK_INDEX_W-1:0] index;
    logic [fpba_pkg::SIZE_FIELD_W-1:0]  bsize;
    logic                               filled;
    logic [fpba_pkg::SIZE_FIELD_W-1:0]  req_size;
  } request_word_t;

  typedef struct packed {
    logic                               granted;
    logic [fpba_pkg::BLOCK_INDEX_W-1:0] chosen;
    logic [fpba_pkg::SIZE_FIELD_W-1:0]  left_over;
  } grant_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [fpba_pkg::ADDR_W-1:0] paddr;
  logic [fpba_pkg::DATA_W-1:0] pwdata, prdata;

  fpba_in_if  req_ch ();
  fpba_out_if rsp_ch ();

  fit_policy_block_allocator uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow state of the allocator
  logic [fpba_pkg::SIZE_WIDTH-1:0]   block_left  [fpba_pkg::NUM_BLOCKS];
  logic                              block_taken [fpba_pkg::NUM_BLOCKS];
  logic [fpba_pkg::POLICY_W-1:0]     policy_reg;
  logic [fpba_pkg::BLOCKS_CFG_W-1:0] blocks_reg;
  grant_t                            expected_grants[$];

  int error_count;
  int words_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h (word %0d)", field, got, want, words_sent);
    error_count++;
  endtask

  // Predict one accepted word against the shadow table
  function automatic void predict_allocation(request_word_t w);
    int     count;
    int     pick;
    logic   found;
    grant_t g;
    if (w.kind == fpba_pkg::REQ_LOAD) begin
      block_left[w.index]  = w.bsize;
      block_taken[w.index] = w.filled;
      return;
    end
    count = (blocks_reg > fpba_pkg::NUM_BLOCKS) ? fpba_pkg::NUM_BLOCKS : int'(blocks_reg);
    found = 1'b0;
    pick  = 0;
    for (int j = 0; j < count; j++) begin
      if (block_taken[j] || block_left[j] < w.req_size) continue;
      if (!found) begin
        found = 1'b1;
        pick  = j;
        if (policy_reg != fpba_pkg::FIT_BEST && policy_reg != fpba_pkg::FIT_WORST) break;
      end else if (policy_reg == fpba_pkg::FIT_BEST && block_left[j] < block_left[pick]) begin
        pick = j;
      end else if (policy_reg == fpba_pkg::FIT_WORST && block_left[j] > block_left[pick]) begin
        pick = j;
      end
    end
    g = '0;
    if (found) begin
      block_left[pick]  = block_left[pick] - w.req_size;
      block_taken[pick] = 1'b1;
      g.granted   = 1'b1;
      g.chosen    = pick[fpba_pkg::BLOCK_INDEX_W-1:0];
      g.left_over = block_left[pick];
    end
    expected_grants.push_back(g);
  endfunction

  // Word builders; unused fields carry random bits
  function automatic request_word_t make_load(int idx, logic [15:0] sz, logic fill);
    request_word_t w;
    w.kind     = fpba_pkg::REQ_LOAD;
    w.index    = idx[fpba_pkg::BLOCK_INDEX_W-1:0];
    w.bsize    = sz;
    w.filled   = fill;
    w.req_size = fpba_pkg::SIZE_FIELD_W'($urandom);
    return w;
  endfunction

  function automatic request_word_t make_alloc(logic [15:0] want);
    request_word_t w;
    w.kind     = fpba_pkg::REQ_ALLOC;
    w.index    = fpba_pkg::BLOCK_INDEX_W'($urandom);
    w.bsize    = fpba_pkg::SIZE_FIELD_W'($urandom);
    w.filled   = 1'($urandom);
    w.req_size = want;
    return w;
  endfunction

  function automatic logic [15:0] rand_block_size();
    case ($urandom_range(7))
      0:       return 16'($urandom_range(65535));
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      default: return 16'($urandom_range(2000));
    endcase
  endfunction

  function automatic logic [15:0] rand_request();
    case ($urandom_range(9))
      0:       return 16'($urandom_range(65535));
      1:       return 16'h0000;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1200));
    endcase
  endfunction

  // Send one word; valid stays high when the next word follows directly
  task automatic send_word(request_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= w.kind;
    req_ch.block_index      <= w.index;
    req_ch.block_size       <= w.bsize;
    req_ch.initially_filled <= w.filled;
    req_ch.request_size     <= w.req_size;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
    predict_allocation(w);
  endtask

  // Drop valid and let the block drain before touching registers
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(fpba_pkg::reg_idx_t r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == fpba_pkg::REG_FIT_POLICY) policy_reg = value[fpba_pkg::POLICY_W-1:0];
    else blocks_reg = value[fpba_pkg::BLOCKS_CFG_W-1:0];
  endtask

  task automatic set_config(logic [fpba_pkg::POLICY_W-1:0] pol,
                            logic [fpba_pkg::BLOCKS_CFG_W-1:0] cnt);
    wait_idle();
    write_register(fpba_pkg::REG_FIT_POLICY, 32'(pol));
    write_register(fpba_pkg::REG_BLOCKS_IN_USE, 32'(cnt));
  endtask

  // Result side: random or held-off ready
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each returned grant word with the oldest prediction
  always @(posedge clk) begin
    grant_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected word", {15'd0, rsp_ch.granted, rsp_ch.left_over}, 0);
      end else begin
        want = expected_grants.pop_front();
        if (rsp_ch.granted !== want.granted)
          report_mismatch("granted", 32'(rsp_ch.granted), 32'(want.granted));
        if (rsp_ch.chosen_block !== want.chosen)
          report_mismatch("chosen_block", 32'(rsp_ch.chosen_block), 32'(want.chosen));
        if (rsp_ch.left_over !== want.left_over)
          report_mismatch("left_over", 32'(rsp_ch.left_over), 32'(want.left_over));
      end
    end
  end

  // Lowest free index wins; zero request, oversize request, all taken
  task automatic test_first_fit();
    set_config(fpba_pkg::FIT_FIRST, 5'd4);
    send_word(make_load(0, 16'hFFFF, 1'b0));
    send_word(make_load(1, 16'h0000, 1'b0));
    send_word(make_load(2, 16'd100, 1'b1));
    send_word(make_load(3, 16'd100, 1'b0));
    send_word(make_load(15, 16'hFFFF, 1'b1));
    send_word(make_alloc(16'h0000));
    send_word(make_alloc(16'hFFFF));
    send_word(make_alloc(16'd50));
    send_word(make_alloc(16'h0000));
    send_word(make_alloc(16'h0000));
  endtask

  // Smallest fitting size, ties to the lower index
  task automatic test_best_fit();
    set_config(fpba_pkg::FIT_BEST, 5'd4);
    send_word(make_load(0, 16'd200, 1'b0));
    send_word(make_load(1, 16'd50, 1'b0));
    send_word(make_load(2, 16'd50, 1'b0));
    send_word(make_load(3, 16'd300, 1'b0));
    send_word(make_alloc(16'd40));
    send_word(make_alloc(16'd60));
  endtask

  task automatic test_worst_fit();
    set_config(fpba_pkg::FIT_WORST, 5'd4);
    send_word(make_alloc(16'd10));
    send_word(make_alloc(16'h0000));
  endtask

  // Spare policy code and an empty scan range
  task automatic test_policy_corners();
    set_config(FIT_SPARE, 5'd4);
    send_word(make_alloc(16'h0000));
    set_config(fpba_pkg::FIT_FIRST, 5'd0);
    send_word(make_alloc(16'd5));
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int n_words);
    int stop_at;
    int seg_len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = words_sent + n_words;
    // every entry loaded before any wide scan
    set_config(2'($urandom_range(3)), 5'd16);
    for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++)
      send_word(make_load(i, rand_block_size(), ($urandom_range(4) == 0)));
    while (words_sent < stop_at) begin
      case ($urandom_range(7))
        0:       set_config(2'($urandom_range(3)), 5'($urandom_range(31)));
        1:       set_config(2'($urandom_range(3)), 5'd16);
        default: set_config(2'($urandom_range(3)), 5'($urandom_range(1, 16)));
      endcase
      seg_len = $urandom_range(10, 40);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(99) < 35)
          send_word(make_load($urandom_range(15), rand_block_size(),
                              ($urandom_range(4) == 0)));
        else
          send_word(make_alloc(rand_request()));
      end
    end
  endtask

  // Results held off long enough that the input backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(fpba_pkg::FIT_BEST, 5'd16);
    for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++)
      send_word(make_load(i, 16'($urandom_range(500, 4000)), 1'b0));
    stall_left <= 400;
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(99) < 30)
        send_word(make_load($urandom_range(15), rand_block_size(), 1'b0));
      else
        send_word(make_alloc(16'($urandom_range(300))));
    end
  endtask

  initial begin
    rst           = 1'b1;
    error_count   = 0;
    words_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left    = 0;
    policy_reg    = fpba_pkg::FIT_FIRST;
    blocks_reg    = '0;
    for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++) begin
      block_left[i]  = '0;
      block_taken[i] = 1'b0;
    end
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    req_ch.valid            <= 1'b0;
    req_ch.req_type         <= fpba_pkg::REQ_LOAD;
    req_ch.block_index      <= '0;
    req_ch.block_size       <= '0;
    req_ch.initially_filled <= 1'b0;
    req_ch.request_size     <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_policy_corners();
    test_random_traffic(38, 45, 590);
    test_random_traffic(45, 38, 590);
    test_random_traffic(0, 0, 590);
    test_output_backpressure();

    wait_idle();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
